@@ src/overflow_hole_fifo_top_macros.svh @@
// Assertion macros shared by the overflow hole FIFO modules.
// Depends on nothing; the asserting module must have clk and rst.
`ifndef OVERFLOW_HOLE_FIFO_TOP_MACROS_SVH
`define OVERFLOW_HOLE_FIFO_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OHF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define OHF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ src/ohf_pkg.sv @@
// Shared types, codes and helper functions of the overflow hole FIFO.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ohf_pkg;

  localparam int THR_W = 6;
  localparam int KW    = 7;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISCARD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [2:0] ST_STORED    = 3'd0;
  localparam logic [2:0] ST_DROPPED   = 3'd1;
  localparam logic [2:0] ST_HOLE      = 3'd2;
  localparam logic [2:0] ST_POPPED    = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_DISCARDED = 3'd5;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_STORE,
    CMD_DROP_START,
    CMD_DROP_CONT,
    CMD_HOLE,
    CMD_EVENT,
    CMD_READ,
    CMD_POP,
    CMD_EMPTY,
    CMD_DISCARD
  } cmd_code_t;

  typedef struct packed {
    logic      load;
    cmd_code_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic run_active;
    logic full;
    logic empty;
    logic can_end;
  } dp_status_t;

  typedef struct packed {
    logic        hole;
    logic [31:0] id;
    logic [31:0] value;
  } entry_t;

  function automatic logic is_result(input cmd_code_t code);
    return code == CMD_STORE || code == CMD_DROP_START || code == CMD_DROP_CONT ||
           code == CMD_EVENT || code == CMD_POP || code == CMD_EMPTY ||
           code == CMD_DISCARD;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ src/ohf_datapath.sv @@
// Datapath of the overflow hole FIFO: entry memory, pointers, drop-run state,
// totals and the result register. Depends on ohf_pkg and the macro header.
`timescale 1ns / 1ps
`include "overflow_hole_fifo_top_macros.svh"

module ohf_datapath #(
  parameter int DEPTH           = 64,
  parameter int DATA_WIDTH      = 32,
  parameter int NOTIFY_INTERVAL = 10000,
  localparam int CNT_W          = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ohf_pkg::ctrl_cmd_t     cmd,
  output ohf_pkg::dp_status_t    st,
  input  logic [1:0]             op,
  input  logic [31:0]            event_id,
  input  logic [31:0]            event_data,
  input  logic [6:0]             discard_count,
  input  logic                   cfg_write,
  input  logic [5:0]             cfg_data,
  output logic [2:0]             status,
  output logic                   entry_is_hole,
  output logic [31:0]            entry_id,
  output logic [31:0]            entry_value,
  output logic [6:0]             removed_count,
  output logic                   progress_notice,
  output logic [CNT_W-1:0]       occupancy,
  output logic [31:0]            total_dropped,
  output logic [31:0]            total_holes
);
  import ohf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = $clog2(NOTIFY_INTERVAL + 1);
  localparam int CW = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int RW = ((CNT_W > KW) ? CNT_W : KW) + 1;
  localparam logic [31:0] DATA_MASK = 32'hFFFF_FFFF >> (32 - DATA_WIDTH);

  // Item registers.
  op_t              op_q;
  logic [31:0]      id_q;
  logic [31:0]      data_q;
  logic [KW-1:0]    k_q;

  // Entry memory, single write port and one registered read.
  entry_t           mem [DEPTH];
  entry_t           rdata;
  logic             mem_we;
  entry_t           mem_wdata;

  logic [PW-1:0]    head, head_next, tail, tail_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [31:0]      run_begin_id;
  logic [31:0]      run_drop_count, run_drop_count_next;
  logic [IW-1:0]    interval_counter, interval_counter_next;
  logic [31:0]      dropped_total, dropped_total_next;
  logic [31:0]      hole_total, hole_total_next;
  logic [THR_W-1:0] threshold;

  logic [CNT_W-1:0] free_n;
  logic [THR_W-1:0] thr_eff;
  logic [PW-1:0]    head_inc, tail_inc;
  logic [RW-1:0]    rem, head_sum, head_disc;
  logic [IW-1:0]    ic_inc;
  logic             ic_wrap;

  logic [2:0]       res_status;
  logic             res_hole;
  logic [31:0]      res_id;
  logic [31:0]      res_val;
  logic [KW-1:0]    res_removed;
  logic             res_notice;

  assign free_n   = CNT_W'(DEPTH) - fill;
  assign thr_eff  = (threshold == '0) ? THR_W'(1) : threshold;
  assign head_inc = (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;
  assign ic_inc   = interval_counter + 1'b1;
  assign ic_wrap  = ic_inc >= IW'(NOTIFY_INTERVAL);

  always_comb begin
    if (op_q != OP_DISCARD) begin
      rem = '0;
    end else if (RW'(k_q) < RW'(fill)) begin
      rem = RW'(k_q);
    end else begin
      rem = RW'(fill);
    end
    head_sum  = RW'(head) + rem;
    head_disc = (head_sum >= RW'(DEPTH)) ? head_sum - RW'(DEPTH) : head_sum;
  end

  assign st.op         = op_q;
  assign st.run_active = run_drop_count != '0;
  assign st.full       = fill == CNT_W'(DEPTH);
  assign st.empty      = fill == '0;
  assign st.can_end    = CW'(free_n) > CW'(thr_eff);

  always_comb begin
    head_next             = head;
    tail_next             = tail;
    fill_next             = fill;
    run_drop_count_next   = run_drop_count;
    interval_counter_next = interval_counter;
    dropped_total_next    = dropped_total;
    hole_total_next       = hole_total;
    mem_we                = 1'b0;
    mem_wdata             = '{hole: 1'b0, id: id_q, value: data_q};
    res_status            = ST_DISCARDED;
    res_hole              = 1'b0;
    res_id                = '0;
    res_val               = '0;
    res_removed           = '0;
    res_notice            = 1'b0;
    case (cmd.code)
      CMD_STORE, CMD_EVENT: begin
        mem_we     = 1'b1;
        tail_next  = tail_inc;
        fill_next  = fill + 1'b1;
        res_status = (cmd.code == CMD_EVENT) ? ST_HOLE : ST_STORED;
      end
      CMD_DROP_START: begin
        run_drop_count_next   = 32'd1;
        interval_counter_next = (NOTIFY_INTERVAL <= 1) ? '0 : IW'(1);
        res_status            = ST_DROPPED;
      end
      CMD_DROP_CONT: begin
        run_drop_count_next   = sat_add32(run_drop_count, 32'd1);
        interval_counter_next = ic_wrap ? '0 : ic_inc;
        res_notice            = ic_wrap;
        res_status            = ST_DROPPED;
      end
      CMD_HOLE: begin
        mem_we                = 1'b1;
        mem_wdata             = '{hole: 1'b1, id: run_begin_id, value: run_drop_count};
        tail_next             = tail_inc;
        fill_next             = fill + 1'b1;
        dropped_total_next    = sat_add32(dropped_total, run_drop_count);
        hole_total_next       = sat_add32(hole_total, 32'd1);
        run_drop_count_next   = '0;
        interval_counter_next = '0;
      end
      CMD_POP: begin
        head_next  = head_inc;
        fill_next  = fill - 1'b1;
        res_status = ST_POPPED;
        res_hole   = rdata.hole;
        res_id     = rdata.id;
        res_val    = rdata.value;
      end
      CMD_EMPTY: begin
        res_status = ST_EMPTY;
      end
      CMD_DISCARD: begin
        head_next   = PW'(head_disc);
        fill_next   = fill - CNT_W'(rem);
        res_removed = KW'(rem);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head             <= '0;
      tail             <= '0;
      fill             <= '0;
      run_drop_count   <= '0;
      interval_counter <= '0;
      dropped_total    <= '0;
      hole_total       <= '0;
      threshold        <= THR_W'(1);
    end else begin
      head             <= head_next;
      tail             <= tail_next;
      fill             <= fill_next;
      run_drop_count   <= run_drop_count_next;
      interval_counter <= interval_counter_next;
      dropped_total    <= dropped_total_next;
      hole_total       <= hole_total_next;
      if (cfg_write) begin
        threshold <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(op);
      id_q   <= event_id;
      data_q <= event_data & DATA_MASK;
      k_q    <= discard_count;
    end
    if (cmd.code == CMD_DROP_START) begin
      run_begin_id <= id_q;
    end
    if (mem_we) begin
      mem[tail] <= mem_wdata;
    end
    if (cmd.code == CMD_READ) begin
      rdata <= mem[head];
    end
    if (is_result(cmd.code)) begin
      status          <= res_status;
      entry_is_hole   <= res_hole;
      entry_id        <= res_id;
      entry_value     <= res_val;
      removed_count   <= res_removed;
      progress_notice <= res_notice;
      occupancy       <= fill_next;
      total_dropped   <= dropped_total_next;
      total_holes     <= hole_total_next;
    end
  end

  `OHF_ASSERT_IMP(a_no_write_when_full, mem_we, fill != CNT_W'(DEPTH), "write into full FIFO")
  `OHF_ASSERT_IMP(a_no_read_when_empty, cmd.code == CMD_READ, fill != '0, "read of empty FIFO")
  `OHF_ASSERT_IMP(a_ptrs_meet, (fill == '0 || fill == CNT_W'(DEPTH)), head == tail, "pointer mismatch")

endmodule

@@ src/ohf_ctrl.sv @@
// Controller of the overflow hole FIFO: sequences one item at a time and
// owns the result valid flag. Depends on ohf_pkg and the macro header.
`timescale 1ns / 1ps
`include "overflow_hole_fifo_top_macros.svh"

module ohf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ohf_pkg::dp_status_t st,
  output ohf_pkg::ctrl_cmd_t  cmd
);
  import ohf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HOLE_EV,
    S_POP
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   result;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;
  assign result   = is_result(cmd.code);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.code   = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (st.op)
          OP_PUSH: begin
            if (st.run_active && st.can_end) begin
              // The hole goes in now; the event follows from S_HOLE_EV once the output is free.
              cmd.code   = CMD_HOLE;
              state_next = S_HOLE_EV;
            end else if (out_free) begin
              if (st.run_active) begin
                cmd.code = CMD_DROP_CONT;
              end else if (st.full) begin
                cmd.code = CMD_DROP_START;
              end else begin
                cmd.code = CMD_STORE;
              end
              state_next = S_IDLE;
            end
          end
          OP_POP: begin
            if (!st.empty) begin
              cmd.code   = CMD_READ;
              state_next = S_POP;
            end else if (out_free) begin
              cmd.code   = CMD_EMPTY;
              state_next = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              cmd.code   = CMD_DISCARD;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_HOLE_EV: begin
        if (out_free) begin
          cmd.code   = CMD_EVENT;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.code   = CMD_POP;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= result || (out_valid && out_stall);
    end
  end

  `OHF_ASSERT_IMP(a_result_needs_room, result, out_free, "result overwrites pending transfer")
  `OHF_ASSERT_IMP(a_pop_after_read, (state == S_POP && $past(state) != S_POP),
                  $past(cmd.code == CMD_READ), "pop without memory read")
  `OHF_ASSERT_IMP(a_hole_on_push, state == S_HOLE_EV, st.op == OP_PUSH, "hole outside push")

endmodule

@@ src/overflow_hole_fifo_top.sv @@
// Top level of the overflow hole FIFO: ports, parameters and the joining of
// controller and datapath. Depends on ohf_pkg, ohf_ctrl and ohf_datapath.
`timescale 1ns / 1ps

// The input channel carries one operation per transfer: a push of an event
// (event_id, event_data), a pop of the head entry, or a discard of up to
// discard_count head entries. The output channel returns exactly one result
// transfer per input transfer, in order, with the status code, the popped
// entry, the number removed, the progress notice, the occupancy after the
// operation and the two saturating totals.
// A push that finds the FIFO full starts a drop run; the run ends on the
// first push that sees more free entries than free_space_threshold (zero counts as one),
// which then writes a hole entry (first dropped id, dropped count) and its event.
// Items are handled one at a time by a small sequencer. A push, a discard
// or an empty pop executes in S_EXEC after it is accepted; a pop also
// passes S_POP, because the entry memory read is registered; a push that
// closes a drop run also passes S_HOLE_EV, because the single memory write
// port stores the hole and the event in separate cycles. The next item is
// accepted when the sequencer returns to S_IDLE as the result is registered.
// While the receiver stalls, the result is held and one further item may be
// accepted, which then waits for the result register to free up.
// Synchronous reset empties the FIFO, clears the run state and totals and
// sets the threshold to one; no clearing pass over the memory is needed.
module overflow_hole_fifo_top #(
  parameter int DEPTH           = 64,
  parameter int DATA_WIDTH      = 32,
  parameter int NOTIFY_INTERVAL = 10000,
  localparam int CNT_W          = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration write of the free space threshold.
  input  logic             cfg_write,
  input  logic [5:0]       cfg_data,
  // Input channel.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  input  logic [31:0]      event_id,
  input  logic [31:0]      event_data,
  input  logic [6:0]       discard_count,
  // Output channel.
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic             entry_is_hole,
  output logic [31:0]      entry_id,
  output logic [31:0]      entry_value,
  output logic [6:0]       removed_count,
  output logic             progress_notice,
  output logic [CNT_W-1:0] occupancy,
  output logic [31:0]      total_dropped,
  output logic [31:0]      total_holes
);
  import ohf_pkg::*;

  // Commands flow from the sequencer to the datapath; status flows back.
  ctrl_cmd_t  cmd;
  dp_status_t st;

  ohf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  ohf_datapath #(
    .DEPTH           (DEPTH),
    .DATA_WIDTH      (DATA_WIDTH),
    .NOTIFY_INTERVAL (NOTIFY_INTERVAL)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .op              (op),
    .event_id        (event_id),
    .event_data      (event_data),
    .discard_count   (discard_count),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .status          (status),
    .entry_is_hole   (entry_is_hole),
    .entry_id        (entry_id),
    .entry_value     (entry_value),
    .removed_count   (removed_count),
    .progress_notice (progress_notice),
    .occupancy       (occupancy),
    .total_dropped   (total_dropped),
    .total_holes     (total_holes)
  );

endmodule
